FILE: rtl/core/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared types and constants for the midpoint circle point generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int QueueDepthDefault = 2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [2:0] PointLast = 3'd7;

  localparam logic signed [13:0] DecInit   = 14'sd3;
  localparam logic signed [15:0] DecIncNeg = 16'sd6;
  localparam logic signed [15:0] DecIncPos = 16'sd10;

  // One octant step handed from front to back: eight points follow from it.
  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [23:0]        color;
    logic               done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [23:0] swap_rb(input logic [23:0] c);
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

FILE: rtl/core/mcpg_front.sv
// ----------------------------------------------------------------------------
// mcpg_front
// Accepts start and step transactions, keeps the circle state and runs the
// midpoint decision update, pushing one job per step while a circle runs.
// ----------------------------------------------------------------------------
module mcpg_front import mcpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic signed [11:0]   center_x,
  input  logic signed [11:0]   center_y,
  input  logic signed [10:0]   radius_in,
  input  logic [23:0]          pen_color,
  input  queue_status_t        q_status,
  output logic                 push,
  output job_t                 push_job
);

  logic               running;
  logic [10:0]        step_x;
  logic signed [11:0] step_y;
  logic signed [13:0] decision;
  logic signed [11:0] centre_x_reg;
  logic signed [11:0] centre_y_reg;
  logic [23:0]        color_reg;

  logic               accept;
  logic signed [11:0] x_ext;
  logic               final_pts;
  logic signed [12:0] diff;
  logic signed [15:0] dec_wide;
  logic signed [13:0] decision_next;
  logic signed [11:0] step_y_next;
  logic [11:0]        step_x_inc;
  logic [10:0]        step_x_next;
  logic               done;
  logic signed [12:0] two_r;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (kind == KIND_STEP) && running;

  assign x_ext     = $signed({1'b0, step_x});
  assign final_pts = (x_ext == step_y);
  assign diff      = 13'(x_ext) - 13'(step_y);
  assign two_r     = {radius_in[10], radius_in, 1'b0};

  always_comb begin
    if (decision[13]) begin
      dec_wide    = 16'(decision) + $signed({3'b000, step_x, 2'b00}) + DecIncNeg;
      step_y_next = step_y;
    end else begin
      dec_wide    = 16'(decision) + $signed({diff[12], diff, 2'b00}) + DecIncPos;
      step_y_next = step_y - 12'sd1;
    end
    step_x_inc = {1'b0, step_x} + 12'd1;
    if (final_pts) begin
      decision_next = decision;
      step_y_next   = step_y;
      step_x_next   = step_x;
      done          = 1'b1;
    end else begin
      decision_next = dec_wide[13:0];
      step_x_next   = step_x_inc[10:0];
      done          = $signed({1'b0, step_x_inc}) > 13'(step_y_next);
    end
  end

  always_comb begin
    push_job.cx    = centre_x_reg;
    push_job.cy    = centre_y_reg;
    push_job.x     = x_ext;
    push_job.y     = step_y;
    push_job.color = swap_rb(color_reg);
    push_job.done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      step_x       <= '0;
      step_y       <= '0;
      decision     <= '0;
      centre_x_reg <= '0;
      centre_y_reg <= '0;
      color_reg    <= '0;
    end else if (accept) begin
      if (kind == KIND_START) begin
        centre_x_reg <= center_x;
        centre_y_reg <= center_y;
        color_reg    <= pen_color;
        step_x       <= '0;
        step_y       <= 12'(radius_in);
        decision     <= DecInit - 14'(two_r);
        running      <= !radius_in[10];
      end else if (running) begin
        decision <= decision_next;
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        running  <= !done;
      end
    end
  end

endmodule

FILE: rtl/core/mcpg_queue.sv
// ----------------------------------------------------------------------------
// mcpg_queue
// Small job FIFO between the front and back halves; head is read directly.
// ----------------------------------------------------------------------------
module mcpg_queue import mcpg_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

FILE: rtl/core/mcpg_back.sv
// ----------------------------------------------------------------------------
// mcpg_back
// Expands each job into its eight symmetric points, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module mcpg_back import mcpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  job_t                 head,
  input  queue_status_t        q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [12:0]   pixel_x,
  output logic signed [12:0]   pixel_y,
  output logic [23:0]          pixel_color,
  output logic                 circle_done
);

  job_t               job;
  logic               active;
  logic [2:0]         idx;
  logic               load;
  logic signed [12:0] u;
  logic signed [12:0] v;
  logic signed [12:0] px;
  logic signed [12:0] py;

  assign load = !out_valid || !out_stall;
  assign pop  = !q_status.empty && (!active || (load && idx == PointLast));

  // idx[2] swaps the roles of x and y, idx[0] negates the x term, idx[1] the y term
  always_comb begin
    u  = idx[2] ? 13'(job.y) : 13'(job.x);
    v  = idx[2] ? 13'(job.x) : 13'(job.y);
    px = 13'(job.cx) + (idx[0] ? -u : u);
    py = 13'(job.cy) + (idx[1] ? -v : v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (load && active) begin
        idx <= idx + 3'd1;
        if (idx == PointLast) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if (load && active) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= job.color;
      circle_done <= job.done && (idx == PointLast);
    end
  end

endmodule

FILE: rtl/core/midpoint_circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_unit
// Midpoint circle rasterizer: start transactions load a circle, each step
// transaction yields the eight symmetric points of the current octant step.
// ----------------------------------------------------------------------------
// A start transaction yields no point. Start and step transactions alike are
// taken only while the job queue has room. A step on a running circle
// yields eight points, delivered one per cycle from the output register
// while the receiver does not stall, so a stream of steps is limited by the
// single point output. The front keeps accepting while fewer than QUEUE_DEPTH
// jobs wait for the back half. The last point of a circle carries circle_done.
// Points are not clipped and the color comes out with red and blue exchanged.
module midpoint_circle_point_generator_unit import mcpg_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic signed [11:0]   center_x,
  input  logic signed [11:0]   center_y,
  input  logic signed [10:0]   radius_in,
  input  logic [23:0]          pen_color,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [12:0]   pixel_x,
  output logic signed [12:0]   pixel_y,
  output logic [23:0]          pixel_color,
  output logic                 circle_done
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;

  mcpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_in (radius_in),
    .pen_color (pen_color),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  mcpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  mcpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .circle_done (circle_done)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_start_no_job: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_START) |-> !push)
    else $error("start transaction produced a job");

  a_empty_idle_out: assert property (@(posedge clk) disable iff (rst)
    (q_status.empty && !push && !out_valid && !$past(pop) && !$past(out_valid))
      |=> !out_valid)
    else $error("point emitted with no job pending");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the midpoint circle point generator. A short table of
// directed transactions is followed by random circles, mostly run to their
// end and sometimes cut off, with random gaps on the input and random stalls
// on the output. Every point is checked against an in-bench circle stepper or typed expected values.
// ----------------------------------------------------------------------------
module tb_top;
  import mcpg_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [3:0] FROM_MODEL = 4'hF;
  localparam int NUM_DIRECTED = 24;

  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [23:0]        color;
    logic               done;
  } pixel_t;

  // exp_pts: number of typed points (0 or 8 copies of ex/ey/ecol), or FROM_MODEL
  typedef struct packed {
    logic               kind;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic signed [10:0] r;
    logic [23:0]        col;
    logic [3:0]         exp_pts;
    logic signed [12:0] ex;
    logic signed [12:0] ey;
    logic [23:0]        ecol;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                kind;
  logic signed [11:0]  center_x;
  logic signed [11:0]  center_y;
  logic signed [10:0]  radius_in;
  logic [23:0]         pen_color;
  logic                out_valid;
  logic                out_stall;
  logic signed [12:0]  pixel_x;
  logic signed [12:0]  pixel_y;
  logic [23:0]         pixel_color;
  logic                circle_done;

  // circle stepper state
  bit                  circ_active;
  int                  cur_x;
  int                  cur_y;
  int                  dec_val;
  logic signed [11:0]  org_x;
  logic signed [11:0]  org_y;
  logic [23:0]         ink;

  pixel_t              pending_pixels[$];
  int                  mismatches;
  int                  cycle_count;
  bit                  no_gaps;
  stim_row_t           directed_rows [NUM_DIRECTED];

  always #5 clk = ~clk;

  midpoint_circle_point_generator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_in   (radius_in),
    .pen_color   (pen_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .circle_done (circle_done)
  );

  // Applies one accepted transaction to the stepper; n is the point count.
  task automatic advance_circle(input logic k, input logic signed [11:0] cx,
                                input logic signed [11:0] cy,
                                input logic signed [10:0] r, input logic [23:0] col,
                                input bit record, output int n);
    int     x, y;
    int     dx[8], dy[8];
    bit     last_pt, fin;
    logic [23:0] swapped;
    pixel_t p;
    n = 0;
    if (k == KIND_START) begin
      org_x       = cx;
      org_y       = cy;
      ink         = col;
      cur_x       = 0;
      cur_y       = r;
      dec_val     = 3 - 2 * int'(r);
      circ_active = (r >= 0);
    end else if (circ_active) begin
      x = cur_x;
      y = cur_y;
      last_pt = (x == y);
      if (!last_pt) begin
        if (dec_val < 0) begin
          dec_val = dec_val + 4 * x + 6;
        end else begin
          dec_val = dec_val + 4 * (x - y) + 10;
          cur_y = y - 1;
        end
        cur_x = x + 1;
      end
      fin = last_pt || (cur_x > cur_y);
      if (fin) circ_active = 1'b0;
      swapped = {ink[7:0], ink[15:8], ink[23:16]};
      dx = '{x, -x, x, -x, y, -y, y, -y};
      dy = '{y, y, -y, -y, x, x, -x, -x};
      n = 8;
      if (record) begin
        for (int i = 0; i < 8; i++) begin
          p.x     = 13'(int'(org_x) + dx[i]);
          p.y     = 13'(int'(org_y) + dy[i]);
          p.color = swapped;
          p.done  = (i == 7) && fin;
          pending_pixels.push_back(p);
        end
      end
    end
  endtask

  task automatic drive_txn(input logic k, input logic signed [11:0] cx,
                           input logic signed [11:0] cy,
                           input logic signed [10:0] r, input logic [23:0] col);
    in_valid  <= 1'b1;
    kind      <= k;
    center_x  <= cx;
    center_y  <= cy;
    radius_in <= r;
    pen_color <= col;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall pattern: short runs and stalls, with the odd long one of each.
  initial begin
    int sel;
    out_stall <= 1'b0;
    forever begin
      sel = $urandom_range(0, 99);
      if (sel < 60) repeat ($urandom_range(1, 4)) @(posedge clk);
      else if (sel < 90) repeat ($urandom_range(5, 30)) @(posedge clk);
      else repeat ($urandom_range(100, 300)) @(posedge clk);
      out_stall <= 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 70) repeat ($urandom_range(1, 2)) @(posedge clk);
      else if (sel < 95) repeat ($urandom_range(3, 8)) @(posedge clk);
      else repeat ($urandom_range(20, 60)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected point x=%0d y=%0d done=%0b", pixel_x, pixel_y, circle_done);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x !== want.x) begin
          $error("pixel_x expected %0d actual %0d", want.x, pixel_x);
          mismatches++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y expected %0d actual %0d", want.y, pixel_y);
          mismatches++;
        end
        if (pixel_color !== want.color) begin
          $error("pixel_color expected %06h actual %06h", want.color, pixel_color);
          mismatches++;
        end
        if (circle_done !== want.done) begin
          $error("circle_done expected %0b actual %0b", want.done, circle_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int     n, counted, sel, tick_cap, ticks;
    logic signed [10:0] rad;
    pixel_t p;
    stim_row_t row;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_START;
    center_x  <= '0;
    center_y  <= '0;
    radius_in <= '0;
    pen_color <= '0;

    directed_rows = '{
      '{KIND_STEP,  12'sh5A5,   12'sh3C3,  11'sh2AA, 24'hC0FFEE, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_START, 12'sd0,     12'sd0,    11'sd0,   24'h123456, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sh7FF,   12'sh800,  11'sh3FF, 24'hFFFFFF, 4'd8, 13'sd0, 13'sd0,
        24'h563412},
      '{KIND_STEP,  12'sd1,     12'sd2,    11'sd3,   24'h000001, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_START, 12'sd2047,  12'sh800,  -11'sd1,  24'hFFFFFF, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sh0F0,   12'sh00F,  11'sh155, 24'h0F0F0F, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_START, 12'sh800,   12'sd2047, 11'sh400, 24'h000000, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'shFFF,   12'shFFF,  11'sh7FF, 24'hAAAAAA, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_START, 12'sd2047,  12'sd2047, 11'sd1023, 24'hFF0000, 4'd0, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sh555,   12'shAAA,  11'sh2AA, 24'h555555, FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      // start while a circle is still in progress
      '{KIND_START, 12'sh800,   12'sh800,  11'sd1023, 24'h0000FF, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_START, 12'sh800,   12'sh800,  11'sd0,   24'hABCDEF, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sd9,     12'sd9,    11'sd9,   24'h999999, 4'd8, -13'sd2048, -13'sd2048,
        24'hEFCDAB},
      // radius one ends on x > y after a single tick
      '{KIND_START, 12'sd100,   -12'sd100, 11'sd1,   24'h00FF00, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      // radius three ends on x == y
      '{KIND_START, -12'sd5,    12'sd7,    11'sd3,   24'h5A5AA5, 4'd0, 13'sd0, 13'sd0, 24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      FROM_MODEL, 13'sd0, 13'sd0,
        24'h0},
      '{KIND_STEP,  12'sd0,     12'sd0,    11'sd0,   24'h0,      4'd0, 13'sd0, 13'sd0, 24'h0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      drive_txn(row.kind, row.cx, row.cy, row.r, row.col);
      advance_circle(row.kind, row.cx, row.cy, row.r, row.col,
                     row.exp_pts == FROM_MODEL, n);
      if (row.exp_pts != FROM_MODEL) begin
        for (int j = 0; j < int'(row.exp_pts); j++) begin
          p.x     = row.ex;
          p.y     = row.ey;
          p.color = row.ecol;
          p.done  = (j == 7);
          pending_pixels.push_back(p);
        end
      end
      pause_sender(pick_gap());
    end

    // let the block empty out completely before the random part
    pause_sender(1);
    while (pending_pixels.size() != 0) @(posedge clk);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      tick_cap = 100000;
      if (sel < 60) begin
        rad = 11'($urandom_range(0, 10));
      end else if (sel < 78) begin
        rad = 11'($urandom_range(11, 40));
      end else if (sel < 88) begin
        rad = 11'(-int'($urandom_range(1, 1024)));
      end else begin
        rad = 11'($urandom_range(41, 1023));
        tick_cap = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 9) == 0) tick_cap = $urandom_range(1, 3);

      drive_txn(KIND_START, 12'($urandom), 12'($urandom), rad, 24'($urandom));
      advance_circle(KIND_START, center_x, center_y, radius_in, pen_color, 1'b1, n);
      counted++;
      pause_sender(pick_gap());

      ticks = 0;
      while (circ_active && ticks < tick_cap) begin
        drive_txn(KIND_STEP, 12'($urandom), 12'($urandom), 11'($urandom), 24'($urandom));
        advance_circle(KIND_STEP, center_x, center_y, radius_in, pen_color, 1'b1, n);
        counted++;
        ticks++;
        pause_sender(pick_gap());
      end

      // occasional ticks with nothing to draw
      if (!circ_active && $urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          drive_txn(KIND_STEP, 12'($urandom), 12'($urandom), 11'($urandom), 24'($urandom));
          advance_circle(KIND_STEP, center_x, center_y, radius_in, pen_color, 1'b1, n);
          pause_sender(pick_gap());
        end
      end

      if ($urandom_range(0, 19) == 0) begin
        pause_sender(1);
        while (pending_pixels.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
